// File: design/smwac_pkg.sv
// Shared types and constants for the smart wake alarm clock controller.
// Used by smwac_window, smwac_core and the top level; depends on nothing.
package smwac_pkg;

   localparam logic [3:0] ACT_TOGGLE     = 4'd0;
   localparam logic [3:0] ACT_SELECT     = 4'd1;
   localparam logic [3:0] ACT_RIGHT      = 4'd2;
   localparam logic [3:0] ACT_LEFT       = 4'd3;
   localparam logic [3:0] ACT_ENC_UP     = 4'd4;
   localparam logic [3:0] ACT_ENC_DOWN   = 4'd5;
   localparam logic [3:0] ACT_TICK       = 4'd6;
   localparam logic [3:0] ACT_TIME       = 4'd7;
   localparam logic [3:0] ACT_STAGE      = 4'd8;

   localparam logic [2:0] MODE_SETCLOCK  = 3'd0;
   localparam logic [2:0] MODE_SETALARM  = 3'd1;
   localparam logic [2:0] MODE_SLEEP     = 3'd2;
   localparam logic [2:0] MODE_WAKE      = 3'd3;
   localparam logic [2:0] MODE_ALARM     = 3'd4;
   localparam logic [2:0] MODE_DONE      = 3'd5;

   localparam logic       CSR_CHECK_PERIOD = 1'b0;
   localparam logic       CSR_WAKE_WINDOW  = 1'b1;

   localparam logic [4:0]  HOURS_TOP      = 5'd23;
   localparam logic [5:0]  MINUTES_TOP    = 6'd59;
   localparam logic [10:0] MINUTES_PER_HR = 11'd60;
   localparam logic [12:0] DAY_MINUTES    = 13'd1440;
   localparam logic [12:0] TWO_DAYS       = 13'd2880;

   localparam logic [5:0]  PERIOD_RESET   = 6'd2;
   localparam logic [10:0] WINDOW_RESET   = 11'd90;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] clk_hours;
      logic [5:0] clk_minutes;
      logic [4:0] alm_hours;
      logic [5:0] alm_minutes;
      logic       clk_sel;
      logic       alm_sel;
      logic       edit_alarm;
      logic [5:0] ticks;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:        MODE_SETCLOCK,
      clk_hours:   5'd0,
      clk_minutes: 6'd0,
      alm_hours:   5'd6,
      alm_minutes: 6'd0,
      clk_sel:     1'b0,
      alm_sel:     1'b0,
      edit_alarm:  1'b0,
      ticks:       6'd0
   };

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] clock_hours_out;
      logic [5:0] clock_minutes_out;
      logic [4:0] alarm_hours_out;
      logic [5:0] alarm_minutes_out;
      logic       editing_minutes;
      logic       commit_pulse;
      logic       wake_pulse;
      logic       motor_pulse;
   } result_type;

   function automatic logic [4:0] step_hours(input logic [4:0] v, input logic up);
      logic [4:0] r;
      if (up) begin
         r = (v < HOURS_TOP) ? v + 5'd1 : 5'd0;
      end else begin
         r = (v > 5'd0) ? v - 5'd1 : HOURS_TOP;
      end
      return r;
   endfunction

   function automatic logic [5:0] step_minutes(input logic [5:0] v, input logic up);
      logic [5:0] r;
      if (up) begin
         r = (v < MINUTES_TOP) ? v + 6'd1 : 6'd0;
      end else begin
         r = (v > 6'd0) ? v - 6'd1 : MINUTES_TOP;
      end
      return r;
   endfunction

endpackage

// File: design/smwac_window.sv
// Wake window test: is the alarm at most the window ahead of the clock, modulo one day.
// Depends on smwac_pkg.
module smwac_window (
   input  logic [4:0]  clk_hours,
   input  logic [5:0]  clk_minutes,
   input  logic [4:0]  alm_hours,
   input  logic [5:0]  alm_minutes,
   input  logic [10:0] window,
   output logic        hit
);
   import smwac_pkg::*;

   logic [10:0] now_min;
   logic [10:0] target_min;
   logic [12:0] diff_raw;
   logic [12:0] diff_half;
   logic [12:0] diff;
   logic        at_alarm;

   always_comb begin
      now_min    = 11'(clk_hours) * MINUTES_PER_HR + 11'(clk_minutes);
      target_min = 11'(alm_hours) * MINUTES_PER_HR + 11'(alm_minutes);
      diff_raw   = 13'(target_min) + TWO_DAYS - 13'(now_min);
      diff_half  = (diff_raw >= TWO_DAYS) ? diff_raw - TWO_DAYS : diff_raw;
      diff       = (diff_half >= DAY_MINUTES) ? diff_half - DAY_MINUTES : diff_half;
      at_alarm   = (clk_hours == alm_hours) && (clk_minutes == alm_minutes);
      hit        = at_alarm || (diff <= 13'(window));
   end

endmodule

// File: design/smwac_core.sv
// Controller state registers and the combinational update for each transfer.
// Depends on smwac_pkg and smwac_window.
module smwac_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [3:0]             action,
   input  logic [4:0]             new_hours,
   input  logic [5:0]             new_minutes,
   input  logic [5:0]             check_period,
   input  logic [10:0]            wake_window,
   output smwac_pkg::result_type  result
);
   import smwac_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      window_hit;
   logic [5:0] ticks_next;
   logic      at_alarm;

   smwac_window u_window (
      .clk_hours   (state_ff.clk_hours),
      .clk_minutes (state_ff.clk_minutes),
      .alm_hours   (state_ff.alm_hours),
      .alm_minutes (state_ff.alm_minutes),
      .window      (wake_window),
      .hit         (window_hit)
   );

   always_comb begin
      state_in   = state_ff;
      result     = '0;
      ticks_next = state_ff.ticks + 6'd1;
      at_alarm   = 1'b0;

      if (state_ff.mode == MODE_SETCLOCK || state_ff.mode == MODE_SETALARM) begin
         if (action == ACT_TOGGLE) begin
            state_in.mode       = (state_ff.mode == MODE_SETCLOCK) ? MODE_SETALARM
                                                                   : MODE_SETCLOCK;
            state_in.edit_alarm = (state_ff.mode == MODE_SETCLOCK);
         end else if (action == ACT_SELECT) begin
            state_in.mode       = MODE_SLEEP;
            state_in.edit_alarm = (state_ff.mode == MODE_SETCLOCK);
            state_in.ticks      = 6'd0;
            result.commit_pulse = 1'b1;
         end else if (action inside {ACT_RIGHT, ACT_LEFT}) begin
            if (state_ff.mode == MODE_SETCLOCK) begin
               state_in.clk_sel = ~state_ff.clk_sel;
            end else begin
               state_in.alm_sel = ~state_ff.alm_sel;
            end
         end else if (action inside {ACT_ENC_UP, ACT_ENC_DOWN}) begin
            if (state_ff.edit_alarm) begin
               if (state_ff.alm_sel) begin
                  state_in.alm_minutes = step_minutes(state_ff.alm_minutes,
                                                      action == ACT_ENC_UP);
               end else begin
                  state_in.alm_hours = step_hours(state_ff.alm_hours, action == ACT_ENC_UP);
               end
            end else begin
               if (state_ff.clk_sel) begin
                  state_in.clk_minutes = step_minutes(state_ff.clk_minutes,
                                                      action == ACT_ENC_UP);
               end else begin
                  state_in.clk_hours = step_hours(state_ff.clk_hours, action == ACT_ENC_UP);
               end
            end
         end
      end else begin
         if (action == ACT_TIME) begin
            state_in.clk_hours   = new_hours;
            state_in.clk_minutes = new_minutes;
         end
         at_alarm = (state_in.clk_hours == state_ff.alm_hours) &&
                    (state_in.clk_minutes == state_ff.alm_minutes);
         case (state_ff.mode)
            MODE_SLEEP: begin
               if (action == ACT_TICK) begin
                  if (ticks_next >= check_period) begin
                     state_in.ticks = 6'd0;
                     if (window_hit) begin
                        state_in.mode     = MODE_WAKE;
                        result.wake_pulse = 1'b1;
                     end
                  end else begin
                     state_in.ticks = ticks_next;
                  end
               end
            end
            MODE_WAKE: begin
               if ((action == ACT_TIME && at_alarm) || action == ACT_STAGE) begin
                  state_in.mode      = MODE_ALARM;
                  result.motor_pulse = 1'b1;
               end
            end
            MODE_ALARM: begin
               if (action <= ACT_LEFT) begin
                  state_in.mode = MODE_DONE;
               end
            end
            MODE_DONE: begin
               if (action == ACT_SELECT) begin
                  state_in.mode       = MODE_SETALARM;
                  state_in.edit_alarm = 1'b1;
               end
            end
            default: begin
               state_in.mode = state_ff.mode;
            end
         endcase
      end

      result.mode              = state_in.mode;
      result.clock_hours_out   = state_in.clk_hours;
      result.clock_minutes_out = state_in.clk_minutes;
      result.alarm_hours_out   = state_in.alm_hours;
      result.alarm_minutes_out = state_in.alm_minutes;
      if (state_in.mode == MODE_SETCLOCK) begin
         result.editing_minutes = state_in.clk_sel;
      end else if (state_in.mode == MODE_SETALARM) begin
         result.editing_minutes = state_in.alm_sel;
      end else begin
         result.editing_minutes = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/smart_wake_alarm_clock_controller_core.sv
// Top level of the smart wake alarm clock controller: request register, result register
// and configuration registers around the controller core. Depends on smwac_pkg, smwac_core.
//
// Each request transfer gives exactly one response transfer. The block takes one request
// per clock cycle while the response side does not stall. The request is registered. The
// controller state is updated from that register, and the response is held in an output
// register, so the response passes the request register and then the output register
// before it is offered. The state update loop through the core allows a sustained rate of
// one event per cycle while the response side does not stall. A request is taken while
// an earlier response still waits, so one response and one request may be held while the
// response side stalls. The user must write configuration through the csr port only while
// no event is in flight; the block itself does not enforce this. There is no read-back.
module smart_wake_alarm_clock_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [4:0]  req_new_hours,
   input  logic [5:0]  req_new_minutes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic [4:0]  rsp_clock_hours_out,
   output logic [5:0]  rsp_clock_minutes_out,
   output logic [4:0]  rsp_alarm_hours_out,
   output logic [5:0]  rsp_alarm_minutes_out,
   output logic        rsp_editing_minutes,
   output logic        rsp_commit_pulse,
   output logic        rsp_wake_pulse,
   output logic        rsp_motor_pulse,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import smwac_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [3:0] in_action_ff;
   logic [4:0] in_hours_ff;
   logic [5:0] in_minutes_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;
   logic [5:0]  period_ff;
   logic [10:0] window_ff;
   logic        out_free;
   logic        advance;
   logic        req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   smwac_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .action       (in_action_ff),
      .new_hours    (in_hours_ff),
      .new_minutes  (in_minutes_ff),
      .check_period (period_ff),
      .wake_window  (window_ff),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
         window_ff    <= WINDOW_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_index == CSR_CHECK_PERIOD) begin
            period_ff <= csr_data[5:0];
         end
         if (csr_write && csr_index == CSR_WAKE_WINDOW) begin
            window_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff  <= req_action;
         in_hours_ff   <= req_new_hours;
         in_minutes_ff <= req_new_minutes;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mode              = rsp_ff.mode;
   assign rsp_clock_hours_out   = rsp_ff.clock_hours_out;
   assign rsp_clock_minutes_out = rsp_ff.clock_minutes_out;
   assign rsp_alarm_hours_out   = rsp_ff.alarm_hours_out;
   assign rsp_alarm_minutes_out = rsp_ff.alarm_minutes_out;
   assign rsp_editing_minutes   = rsp_ff.editing_minutes;
   assign rsp_commit_pulse      = rsp_ff.commit_pulse;
   assign rsp_wake_pulse        = rsp_ff.wake_pulse;
   assign rsp_motor_pulse       = rsp_ff.motor_pulse;

endmodule

// File: tb/tb_smart_wake_alarm_clock_controller_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the smart wake alarm clock controller core: a directed
// walk through every mode, then guided random events under several register settings.
// Depends on smwac_pkg and smart_wake_alarm_clock_controller_core.
module tb_smart_wake_alarm_clock_controller_core;
   import smwac_pkg::*;

   localparam logic [3:0] ACT_UNUSED_TOP = 4'd15;

   typedef struct packed {
      logic [3:0] action;
      logic [4:0] hours;
      logic [5:0] minutes;
   } clock_event_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] clk_hours;
      logic [5:0] clk_minutes;
      logic [4:0] alm_hours;
      logic [5:0] alm_minutes;
      logic       clk_sel;
      logic       alm_sel;
      logic       edit_alarm;
      logic [5:0] ticks;
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] clock_hours;
      logic [5:0] clock_minutes;
      logic [4:0] alarm_hours;
      logic [5:0] alarm_minutes;
      logic       editing_minutes;
      logic       commit;
      logic       wake;
      logic       motor;
   } clock_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_action = '0;
   logic [4:0]  req_new_hours = '0;
   logic [5:0]  req_new_minutes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_mode;
   logic [4:0]  rsp_clock_hours_out;
   logic [5:0]  rsp_clock_minutes_out;
   logic [4:0]  rsp_alarm_hours_out;
   logic [5:0]  rsp_alarm_minutes_out;
   logic        rsp_editing_minutes;
   logic        rsp_commit_pulse;
   logic        rsp_wake_pulse;
   logic        rsp_motor_pulse;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [10:0] csr_data = '0;

   smart_wake_alarm_clock_controller_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_new_hours(req_new_hours),
      .req_new_minutes(req_new_minutes),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mode(rsp_mode),
      .rsp_clock_hours_out(rsp_clock_hours_out),
      .rsp_clock_minutes_out(rsp_clock_minutes_out),
      .rsp_alarm_hours_out(rsp_alarm_hours_out),
      .rsp_alarm_minutes_out(rsp_alarm_minutes_out),
      .rsp_editing_minutes(rsp_editing_minutes),
      .rsp_commit_pulse(rsp_commit_pulse),
      .rsp_wake_pulse(rsp_wake_pulse),
      .rsp_motor_pulse(rsp_motor_pulse),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [5:0]      period_cfg = PERIOD_RESET;
   logic [10:0]     window_cfg = WINDOW_RESET;
   ctrl_state_type  model_state;
   ctrl_state_type  plan_state;
   clock_event_type pending_events[$];
   clock_view_type  expected_views[$];
   clock_event_type offered_event;
   clock_view_type  predicted;
   clock_view_type  wanted;
   int           send_gap = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   int           backlog_requests = 0;
   int           backlog_served = 0;
   bit           calm = 1'b0;
   logic         stall_next;
   int           mismatches = 0;
   int           responses_checked = 0;
   int           commit_count = 0;
   int           wake_count = 0;
   int           motor_count = 0;

   function automatic ctrl_state_type power_on_state();
      ctrl_state_type s;
      s = '0;
      s.mode = MODE_SETCLOCK;
      s.alm_hours = 5'd6;
      return s;
   endfunction

   function automatic int wrap_step(int value, int top, logic up);
      if (up) return (value < top) ? value + 1 : 0;
      return (value > 0) ? value - 1 : top;
   endfunction

   function automatic clock_event_type make_event(logic [3:0] action, int hours, int minutes);
      clock_event_type ev;
      ev.action = action;
      ev.hours = 5'(hours);
      ev.minutes = 6'(minutes);
      return ev;
   endfunction

   // Applies one event to a copy of the controller state and returns the response it gives.
   task automatic apply_event(inout ctrl_state_type s, input clock_event_type ev,
                              output clock_view_type v);
      int   now_min;
      int   alarm_min;
      int   ahead;
      logic at_alarm;
      logic up;
      logic from_clock;
      v = '0;
      from_clock = (s.mode == MODE_SETCLOCK);
      if (s.mode == MODE_SETCLOCK || s.mode == MODE_SETALARM) begin
         case (ev.action)
            ACT_TOGGLE: begin
               s.edit_alarm = from_clock;
               s.mode = from_clock ? MODE_SETALARM : MODE_SETCLOCK;
            end
            ACT_SELECT: begin
               s.edit_alarm = from_clock;
               s.mode = MODE_SLEEP;
               s.ticks = '0;
               v.commit = 1'b1;
            end
            ACT_RIGHT, ACT_LEFT: begin
               if (from_clock) s.clk_sel = ~s.clk_sel;
               else s.alm_sel = ~s.alm_sel;
            end
            ACT_ENC_UP, ACT_ENC_DOWN: begin
               up = (ev.action == ACT_ENC_UP);
               if (s.edit_alarm) begin
                  if (s.alm_sel) s.alm_minutes = 6'(wrap_step(s.alm_minutes, MINUTES_TOP, up));
                  else s.alm_hours = 5'(wrap_step(s.alm_hours, HOURS_TOP, up));
               end else begin
                  if (s.clk_sel) s.clk_minutes = 6'(wrap_step(s.clk_minutes, MINUTES_TOP, up));
                  else s.clk_hours = 5'(wrap_step(s.clk_hours, HOURS_TOP, up));
               end
            end
            default: ;
         endcase
      end else begin
         if (ev.action == ACT_TIME) begin
            s.clk_hours = ev.hours;
            s.clk_minutes = ev.minutes;
         end
         at_alarm = (s.clk_hours == s.alm_hours) && (s.clk_minutes == s.alm_minutes);
         case (s.mode)
            MODE_SLEEP: begin
               if (ev.action == ACT_TICK) begin
                  s.ticks = s.ticks + 6'd1;
                  if (s.ticks >= period_cfg) begin
                     s.ticks = '0;
                     now_min = s.clk_hours * 60 + s.clk_minutes;
                     alarm_min = s.alm_hours * 60 + s.alm_minutes;
                     ahead = (alarm_min + 2 * int'(DAY_MINUTES) - now_min) % int'(DAY_MINUTES);
                     if (at_alarm || ahead <= int'(window_cfg)) begin
                        s.mode = MODE_WAKE;
                        v.wake = 1'b1;
                     end
                  end
               end
            end
            MODE_WAKE: begin
               if ((ev.action == ACT_TIME && at_alarm) || ev.action == ACT_STAGE) begin
                  s.mode = MODE_ALARM;
                  v.motor = 1'b1;
               end
            end
            MODE_ALARM: begin
               if (ev.action <= ACT_LEFT) s.mode = MODE_DONE;
            end
            MODE_DONE: begin
               if (ev.action == ACT_SELECT) begin
                  s.mode = MODE_SETALARM;
                  s.edit_alarm = 1'b1;
               end
            end
            default: ;
         endcase
      end
      v.mode = s.mode;
      v.clock_hours = s.clk_hours;
      v.clock_minutes = s.clk_minutes;
      v.alarm_hours = s.alm_hours;
      v.alarm_minutes = s.alm_minutes;
      if (s.mode == MODE_SETCLOCK) v.editing_minutes = s.clk_sel;
      else if (s.mode == MODE_SETALARM) v.editing_minutes = s.alm_sel;
   endtask

   task automatic queue_event(input clock_event_type ev);
      clock_view_type scratch;
      apply_event(plan_state, ev, scratch);
      pending_events.push_back(ev);
   endtask

   function automatic int rand_hours();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
   endfunction

   function automatic int rand_minutes();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
   endfunction

   // Picks the next event from the mode the controller will be in, so that most
   // sequences run through sleep, wake and alarm instead of stalling in the set modes.
   task automatic plan_event(output bit counted);
      clock_event_type ev;
      int pick;
      int offset;
      int target;
      pick = $urandom_range(0, 99);
      ev = make_event(ACT_TICK, rand_hours(), rand_minutes());
      offset = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
      target = (plan_state.alm_hours * 60 + plan_state.alm_minutes - offset
                + int'(DAY_MINUTES)) % int'(DAY_MINUTES);
      if (pick < 8) begin
         ev.action = 4'($urandom_range(ACT_TOGGLE, ACT_UNUSED_TOP));
      end else begin
         case (plan_state.mode)
            MODE_SETCLOCK, MODE_SETALARM: begin
               if (pick < 18) ev.action = ACT_TOGGLE;
               else if (pick < 26) ev.action = ACT_SELECT;
               else if (pick < 40) ev.action = pick[0] ? ACT_RIGHT : ACT_LEFT;
               else ev.action = pick[0] ? ACT_ENC_UP : ACT_ENC_DOWN;
            end
            MODE_SLEEP: begin
               if (pick < 55) begin
                  ev.action = ACT_TICK;
               end else if (pick < 85) begin
                  ev = make_event(ACT_TIME, target / 60, target % 60);
               end else begin
                  ev.action = ACT_TIME;
               end
            end
            MODE_WAKE: begin
               if (pick < 30) ev = make_event(ACT_TIME, plan_state.alm_hours,
                                              plan_state.alm_minutes);
               else if (pick < 45) ev.action = ACT_STAGE;
               else if (pick < 70) ev = make_event(ACT_TIME, target / 60, target % 60);
               else ev.action = 4'($urandom_range(ACT_TOGGLE, ACT_UNUSED_TOP));
            end
            MODE_ALARM: begin
               if (pick < 40) ev.action = 4'($urandom_range(ACT_TOGGLE, ACT_LEFT));
               else ev.action = 4'($urandom_range(ACT_ENC_UP, ACT_UNUSED_TOP));
            end
            default: begin
               if (pick < 35) ev.action = ACT_SELECT;
               else ev.action = 4'($urandom_range(ACT_TOGGLE, ACT_UNUSED_TOP));
            end
         endcase
      end
      counted = (ev.action <= ACT_STAGE);
      queue_event(ev);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_event(model_state, offered_event, predicted);
            expected_views.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               offered_event = pending_events.pop_front();
               req_action <= offered_event.action;
               req_new_hours <= offered_event.hours;
               req_new_minutes <= offered_event.minutes;
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               $display("%0t: response transfer with nothing expected, actual mode %0d",
                        $time, rsp_mode);
               mismatches++;
            end else begin
               wanted = expected_views.pop_front();
               responses_checked++;
               commit_count += wanted.commit;
               wake_count += wanted.wake;
               motor_count += wanted.motor;
               compare_field("mode", wanted.mode, rsp_mode);
               compare_field("clock_hours_out", wanted.clock_hours, rsp_clock_hours_out);
               compare_field("clock_minutes_out", wanted.clock_minutes,
                             rsp_clock_minutes_out);
               compare_field("alarm_hours_out", wanted.alarm_hours, rsp_alarm_hours_out);
               compare_field("alarm_minutes_out", wanted.alarm_minutes,
                             rsp_alarm_minutes_out);
               compare_field("editing_minutes", wanted.editing_minutes, rsp_editing_minutes);
               compare_field("commit_pulse", wanted.commit, rsp_commit_pulse);
               compare_field("wake_pulse", wanted.wake, rsp_wake_pulse);
               compare_field("motor_pulse", wanted.motor, rsp_motor_pulse);
            end
         end
         if (backlog_requests != backlog_served) begin
            backlog_served = backlog_requests;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic write_register(input logic index, input logic [10:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_CHECK_PERIOD) period_cfg = value[5:0];
      else window_cfg = value;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_views.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   int period_list[6] = '{2, 1, 63, 0, 7, 3};
   int window_list[6] = '{90, 0, 1439, 2047, 30, 600};

   initial begin
      int phase;
      int counted;
      bit hit;
      model_state = power_on_state();
      plan_state = power_on_state();

      // Directed walk: clock fields wrap at both ends, alarm minutes at the low end,
      // out-of-range times, ignored codes, window wake and motor on a matching time update.
      queue_event(make_event(ACT_ENC_DOWN, 0, 0));
      queue_event(make_event(ACT_ENC_UP, 0, 0));
      queue_event(make_event(ACT_RIGHT, 0, 0));
      queue_event(make_event(ACT_ENC_DOWN, 0, 0));
      queue_event(make_event(ACT_ENC_UP, 0, 0));
      queue_event(make_event(ACT_LEFT, 0, 0));
      queue_event(make_event(ACT_TOGGLE, 0, 0));
      queue_event(make_event(ACT_ENC_UP, 0, 0));
      queue_event(make_event(ACT_RIGHT, 0, 0));
      queue_event(make_event(ACT_ENC_DOWN, 0, 0));
      queue_event(make_event(ACT_UNUSED_TOP, 31, 63));
      queue_event(make_event(ACT_TIME, 31, 63));
      queue_event(make_event(ACT_TOGGLE, 0, 0));
      queue_event(make_event(ACT_TOGGLE, 0, 0));
      queue_event(make_event(ACT_SELECT, 0, 0));
      queue_event(make_event(ACT_TIME, 31, 63));
      queue_event(make_event(ACT_TICK, 0, 0));
      queue_event(make_event(ACT_TIME, 7, 0));
      queue_event(make_event(ACT_TICK, 0, 0));
      queue_event(make_event(ACT_TICK, 0, 0));
      queue_event(make_event(ACT_TIME, 7, 59));
      queue_event(make_event(ACT_STAGE, 0, 0));
      queue_event(make_event(ACT_RIGHT, 0, 0));
      queue_event(make_event(ACT_SELECT, 0, 0));
      queue_event(make_event(ACT_TOGGLE, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            wait_idle();
            write_register(CSR_CHECK_PERIOD, 11'(period_list[phase]));
            write_register(CSR_WAKE_WINDOW, 11'(window_list[phase]));
         end
         if (phase == 2) backlog_requests++;
         if (phase == 5) calm = 1'b1;
         counted = 0;
         while (counted < 225) begin
            plan_event(hit);
            if (hit) counted++;
         end
      end
      wait_idle();
      repeat (8) @(negedge clock);

      $display("Checked %0d responses under 6 register settings.", responses_checked);
      $display("Saw %0d commits, %0d wake-ups and %0d alarms fired.",
               commit_count, wake_count, motor_count);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still expected", expected_views.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: smart_wake_alarm_clock_controller_core.f
design/smwac_pkg.sv
design/smwac_window.sv
design/smwac_core.sv
design/smart_wake_alarm_clock_controller_core.sv
tb/tb_smart_wake_alarm_clock_controller_core.sv
